// File: design/rkih_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rkih_pkg
// Types and constants shared by the rotary knob input handler files.
// ----------------------------------------------------------------------------
package rkih_pkg;

    // Request codes
    typedef logic [1:0] t_req_type;
    localparam t_req_type REQ_TICK   = 2'd0;
    localparam t_req_type REQ_A_FALL = 2'd1;
    localparam t_req_type REQ_B_FALL = 2'd2;
    localparam t_req_type REQ_BUTTON = 2'd3;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 10;
    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;
    localparam t_cfg_addr REG_ROTARY_LOCKOUT = 4'd0;
    localparam t_cfg_addr REG_BUTTON_LOCKOUT = 4'd1;
    localparam t_cfg_addr REG_WRAP_MID       = 4'd2;
    localparam t_cfg_addr REG_WRAP_LARGE     = 4'd3;

    // Reset values of the configuration registers
    localparam logic [9:0] ROTARY_LOCKOUT_RST = 10'd15;
    localparam logic [9:0] BUTTON_LOCKOUT_RST = 10'd150;
    localparam logic [7:0] WRAP_MID_RST       = 8'd40;
    localparam logic [7:0] WRAP_LARGE_RST     = 8'd255;

    localparam logic [3:0]  MODE_RST     = 4'd6;
    localparam logic [3:0]  MODE_MID_MAX = 4'd5;
    localparam logic [10:0] ELAPSED_MAX  = 11'd2047;

    typedef struct packed {
        t_req_type req_type;
        logic      level_a;
        logic      level_b;
        logic      level_button;
    } t_item;

    typedef struct packed {
        logic [7:0]  position;
        logic [3:0]  mode;
        logic        toggle;
        logic [10:0] rotary_elapsed;
        logic [10:0] button_elapsed;
    } t_state;

    typedef struct packed {
        logic [9:0] rotary_lockout;
        logic [9:0] button_lockout;
        logic [7:0] wrap_mid;
        logic [7:0] wrap_large;
    } t_cfg;

    typedef struct packed {
        logic [7:0] position;
        logic [3:0] mode_now;
        logic       toggle_flag;
        logic       accepted;
    } t_result;

endpackage
`default_nettype wire

// File: design/rkih_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rkih_in_if
// Input channel: one tick or edge event per transaction.
// ----------------------------------------------------------------------------
interface rkih_in_if;
    import rkih_pkg::*;

    logic      valid;
    logic      ready;
    t_req_type req_type;
    logic      level_a;
    logic      level_b;
    logic      level_button;

    modport source (output valid, output req_type, output level_a, output level_b,
                    output level_button, input ready);
    modport sink   (input valid, input req_type, input level_a, input level_b,
                    input level_button, output ready);
endinterface
`default_nettype wire

// File: design/rkih_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rkih_out_if
// Result channel: knob state after each input transaction.
// ----------------------------------------------------------------------------
interface rkih_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] position;
    logic [3:0] mode_now;
    logic       toggle_flag;
    logic       accepted;

    modport source (output valid, output position, output mode_now, output toggle_flag,
                    output accepted, input ready);
    modport sink   (input valid, input position, input mode_now, input toggle_flag,
                    input accepted, output ready);
endinterface
`default_nettype wire

// File: design/rkih_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rkih_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rkih_cfg_if;
    import rkih_pkg::*;

    logic      valid;
    logic      ready;
    t_cfg_addr addr;
    t_cfg_data data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

// File: design/rotary_knob_input_handler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotary_knob_input_handler
// Knob position, mode and toggle tracking with lockout debounce.
// ----------------------------------------------------------------------------
// Takes one transaction per clock unless the result side stalls: a millisecond
// tick, an A or B falling edge, or a button rising edge. It returns one result
// per transaction with the position, mode and toggle after it and whether the
// edge took effect. An item passes an input register and then a result
// register; a stall on the result side holds it in the input register. The
// single-pass update between the registers
// keeps the sustained rate at one item per cycle as long as the result side
// takes one result per cycle. Configuration writes are taken at any time, ready
// is always high, and are meant to be made while no item is in flight.
module rotary_knob_input_handler #(
    parameter int LED_COUNT  = 8,
    parameter int MODE_COUNT = 9
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    rkih_in_if.sink   i_in,
    rkih_cfg_if.sink  i_cfg,
    rkih_out_if.source o_out
);
    import rkih_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_item   r_item;
    logic    r_in_valid;
    t_result r_res;
    logic    r_out_valid;
    logic    n_accepted;
    logic    advance;
    logic    proc;

    assign advance   = !r_out_valid || o_out.ready;
    assign proc      = r_in_valid && advance;
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotary_lockout <= ROTARY_LOCKOUT_RST;
            r_cfg.button_lockout <= BUTTON_LOCKOUT_RST;
            r_cfg.wrap_mid       <= WRAP_MID_RST;
            r_cfg.wrap_large     <= WRAP_LARGE_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                REG_ROTARY_LOCKOUT: r_cfg.rotary_lockout <= i_cfg.data;
                REG_BUTTON_LOCKOUT: r_cfg.button_lockout <= i_cfg.data;
                REG_WRAP_MID:       r_cfg.wrap_mid       <= i_cfg.data[7:0];
                REG_WRAP_LARGE:     r_cfg.wrap_large     <= i_cfg.data[7:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.req_type     <= i_in.req_type;
            r_item.level_a      <= i_in.level_a;
            r_item.level_b      <= i_in.level_b;
            r_item.level_button <= i_in.level_button;
        end
    end

    rkih_step #(
        .LED_COUNT  (LED_COUNT),
        .MODE_COUNT (MODE_COUNT)
    ) u_step (
        .i_item     (r_item),
        .i_state    (r_state),
        .i_cfg      (r_cfg),
        .o_state    (n_state),
        .o_accepted (n_accepted)
    );

    // Knob state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.position       <= 8'd0;
            r_state.mode           <= MODE_RST;
            r_state.toggle         <= 1'b0;
            r_state.rotary_elapsed <= 11'd0;
            r_state.button_elapsed <= 11'd0;
            r_out_valid            <= 1'b0;
        end else begin
            if (proc) begin
                r_state <= n_state;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_res.position    <= n_state.position;
            r_res.mode_now    <= n_state.mode;
            r_res.toggle_flag <= n_state.toggle;
            r_res.accepted    <= n_accepted;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.position    = r_res.position;
    assign o_out.mode_now    = r_res.mode_now;
    assign o_out.toggle_flag = r_res.toggle_flag;
    assign o_out.accepted    = r_res.accepted;

    // The position never reaches 255: up-steps wrap before it, down-steps stop at limit-1
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.position != 8'hFF)
        else $error("knob position reached 255");

    // The toggle only moves when a button transaction is processed
    a_toggle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(proc && r_item.req_type == REQ_BUTTON) |=> $stable(r_state.toggle))
        else $error("toggle changed without a button press");

    // Accepted knob step restarts the knob lockout
    a_rot_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && n_accepted && r_item.req_type != REQ_BUTTON)
        |=> r_state.rotary_elapsed == 11'd0)
        else $error("knob lockout not restarted");

    // Entering mode 0 leaves the position inside the LED ring
    a_mode0_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && n_accepted && r_item.req_type == REQ_BUTTON && n_state.mode == 4'd0)
        |=> r_state.position < 8'(LED_COUNT))
        else $error("position outside LED ring after entering mode 0");

endmodule
`default_nettype wire

// File: design/rkih_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rkih_step
// Single-pass next-state logic for one tick or edge event.
// ----------------------------------------------------------------------------
module rkih_step #(
    parameter int LED_COUNT  = 8,
    parameter int MODE_COUNT = 9
) (
    input  rkih_pkg::t_item  i_item,
    input  rkih_pkg::t_state i_state,
    input  rkih_pkg::t_cfg   i_cfg,
    output rkih_pkg::t_state o_state,
    output logic             o_accepted
);
    import rkih_pkg::*;

    // position mod LED_COUNT for every 8-bit position, built at elaboration
    function automatic logic [255:0][7:0] build_mod_tbl();
        logic [255:0][7:0] tbl;
        for (int i = 0; i < 256; i++) begin
            tbl[i] = 8'(i % LED_COUNT);
        end
        return tbl;
    endfunction

    localparam logic [255:0][7:0] MOD_TBL = build_mod_tbl();

    logic [7:0]  wrap_raw;
    logic [7:0]  wrap;
    logic [8:0]  pos_inc;
    logic [4:0]  mode_inc;
    logic [3:0]  mode_adv;
    logic        rot_open;
    logic        btn_open;
    logic [10:0] rot_inc;
    logic [10:0] btn_inc;

    always_comb begin
        if (i_state.mode == 4'd0) begin
            wrap_raw = 8'(LED_COUNT);
        end else if (i_state.mode <= MODE_MID_MAX) begin
            wrap_raw = i_cfg.wrap_mid;
        end else begin
            wrap_raw = i_cfg.wrap_large;
        end
        wrap = (wrap_raw == 8'd0) ? 8'd1 : wrap_raw;
    end

    assign pos_inc  = {1'b0, i_state.position} + 9'd1;
    assign mode_inc = {1'b0, i_state.mode} + 5'd1;
    assign mode_adv = (mode_inc >= 5'(MODE_COUNT)) ? 4'd0 : mode_inc[3:0];
    assign rot_open = i_state.rotary_elapsed > {1'b0, i_cfg.rotary_lockout};
    assign btn_open = i_state.button_elapsed > {1'b0, i_cfg.button_lockout};
    assign rot_inc  = (i_state.rotary_elapsed == ELAPSED_MAX) ? ELAPSED_MAX
                                                             : i_state.rotary_elapsed + 11'd1;
    assign btn_inc  = (i_state.button_elapsed == ELAPSED_MAX) ? ELAPSED_MAX
                                                             : i_state.button_elapsed + 11'd1;

    always_comb begin
        o_state    = i_state;
        o_accepted = 1'b0;
        unique case (i_item.req_type)
            REQ_TICK: begin
                o_state.rotary_elapsed = rot_inc;
                o_state.button_elapsed = btn_inc;
            end
            REQ_A_FALL: begin
                if (rot_open && i_item.level_b && !i_item.level_a) begin
                    o_state.position       = (pos_inc >= {1'b0, wrap}) ? 8'd0 : pos_inc[7:0];
                    o_state.rotary_elapsed = 11'd0;
                    o_accepted             = 1'b1;
                end
            end
            REQ_B_FALL: begin
                if (rot_open && i_item.level_a && !i_item.level_b) begin
                    // at zero, or left above a lowered limit: jump to the top
                    if (i_state.position == 8'd0 || i_state.position > wrap) begin
                        o_state.position = wrap - 8'd1;
                    end else begin
                        o_state.position = i_state.position - 8'd1;
                    end
                    o_state.rotary_elapsed = 11'd0;
                    o_accepted             = 1'b1;
                end
            end
            REQ_BUTTON: begin
                if (btn_open && i_item.level_button) begin
                    o_state.toggle         = ~i_state.toggle;
                    o_state.mode           = mode_adv;
                    o_state.button_elapsed = 11'd0;
                    if (mode_adv == 4'd0) begin
                        o_state.position = MOD_TBL[i_state.position];
                    end
                    o_accepted = 1'b1;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: tb/rkih_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rkih_checker
// Watches the knob handler channels, predicts every result and compares.
// ----------------------------------------------------------------------------
// Keeps its own copy of the knob state and the configuration registers. Each
// input transaction is run through the knob update and its expected result is
// queued. Each result transaction is compared field by field with the oldest
// queued result. The failure count and the number of outstanding results go
// to the testbench top.
module rkih_checker #(
    parameter int LED_COUNT  = 8,
    parameter int MODE_COUNT = 9
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    rkih_in_if   i_in_ch,
    rkih_cfg_if  i_cfg_ch,
    rkih_out_if  i_out_ch,
    output int   o_err_count,
    output int   o_pending
);
    import rkih_pkg::*;

    t_state  knob;
    t_cfg    regs;
    t_result expected_knob_q[$];
    int      result_idx;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH result %0d %s: got %0d, expected %0d", result_idx, what, got, want);
        o_err_count = o_err_count + 1;
    endtask

    function automatic logic [10:0] tick_count(input logic [10:0] v);
        return (v >= ELAPSED_MAX) ? ELAPSED_MAX : v + 11'd1;
    endfunction

    // Knob update for one event; returns the state seen after it
    task automatic apply_knob_event(input t_item ev, output t_result res);
        logic [8:0] lim;
        logic [8:0] nxt;
        logic [4:0] m;
        logic       acc;
        acc = 1'b0;
        if (knob.mode == 4'd0) begin
            lim = 9'(LED_COUNT);
        end else if (knob.mode <= MODE_MID_MAX) begin
            lim = {1'b0, regs.wrap_mid};
        end else begin
            lim = {1'b0, regs.wrap_large};
        end
        if (lim == 9'd0) lim = 9'd1;

        case (ev.req_type)
            REQ_TICK: begin
                knob.rotary_elapsed = tick_count(knob.rotary_elapsed);
                knob.button_elapsed = tick_count(knob.button_elapsed);
            end
            REQ_A_FALL: begin
                if ({1'b0, knob.rotary_elapsed} > {2'b0, regs.rotary_lockout} &&
                    ev.level_b && !ev.level_a) begin
                    nxt = {1'b0, knob.position} + 9'd1;
                    knob.position = (nxt >= lim) ? 8'd0 : nxt[7:0];
                    knob.rotary_elapsed = '0;
                    acc = 1'b1;
                end
            end
            REQ_B_FALL: begin
                if ({1'b0, knob.rotary_elapsed} > {2'b0, regs.rotary_lockout} &&
                    ev.level_a && !ev.level_b) begin
                    // compare-based wrap, position may sit above a lowered limit
                    if (knob.position == 8'd0 || {1'b0, knob.position} > lim)
                        knob.position = 8'(lim - 9'd1);
                    else
                        knob.position = knob.position - 8'd1;
                    knob.rotary_elapsed = '0;
                    acc = 1'b1;
                end
            end
            REQ_BUTTON: begin
                if ({1'b0, knob.button_elapsed} > {2'b0, regs.button_lockout} &&
                    ev.level_button) begin
                    m = {1'b0, knob.mode} + 5'd1;
                    knob.toggle = ~knob.toggle;
                    knob.mode = (int'(m) >= MODE_COUNT) ? 4'd0 : m[3:0];
                    if (knob.mode == 4'd0)
                        knob.position = 8'(int'(knob.position) % LED_COUNT);
                    knob.button_elapsed = '0;
                    acc = 1'b1;
                end
            end
            default: ;
        endcase

        res = '{position: knob.position, mode_now: knob.mode,
                toggle_flag: knob.toggle, accepted: acc};
    endtask

    always @(posedge i_clk) begin
        t_item   ev;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            knob = '{position: 8'd0, mode: MODE_RST, toggle: 1'b0,
                     rotary_elapsed: 11'd0, button_elapsed: 11'd0};
            regs = '{rotary_lockout: ROTARY_LOCKOUT_RST, button_lockout: BUTTON_LOCKOUT_RST,
                     wrap_mid: WRAP_MID_RST, wrap_large: WRAP_LARGE_RST};
            expected_knob_q.delete();
            result_idx = 0;
        end else begin
            if (i_cfg_ch.valid && i_cfg_ch.ready) begin
                case (i_cfg_ch.addr)
                    REG_ROTARY_LOCKOUT: regs.rotary_lockout = i_cfg_ch.data[9:0];
                    REG_BUTTON_LOCKOUT: regs.button_lockout = i_cfg_ch.data[9:0];
                    REG_WRAP_MID:       regs.wrap_mid       = i_cfg_ch.data[7:0];
                    REG_WRAP_LARGE:     regs.wrap_large     = i_cfg_ch.data[7:0];
                    default: ;
                endcase
            end

            if (i_out_ch.valid && i_out_ch.ready) begin
                got = '{position: i_out_ch.position, mode_now: i_out_ch.mode_now,
                        toggle_flag: i_out_ch.toggle_flag, accepted: i_out_ch.accepted};
                if (expected_knob_q.size() == 0) begin
                    report_mismatch("arrived with nothing expected, position",
                                    got.position, -1);
                end else begin
                    want = expected_knob_q.pop_front();
                    if (got.position !== want.position)
                        report_mismatch("position", got.position, want.position);
                    if (got.mode_now !== want.mode_now)
                        report_mismatch("mode_now", got.mode_now, want.mode_now);
                    if (got.toggle_flag !== want.toggle_flag)
                        report_mismatch("toggle_flag", got.toggle_flag, want.toggle_flag);
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", got.accepted, want.accepted);
                end
                result_idx = result_idx + 1;
            end

            if (i_in_ch.valid && i_in_ch.ready) begin
                ev = '{req_type: i_in_ch.req_type, level_a: i_in_ch.level_a,
                       level_b: i_in_ch.level_b, level_button: i_in_ch.level_button};
                apply_knob_event(ev, want);
                expected_knob_q.push_back(want);
            end
        end
        o_pending <= expected_knob_q.size();
    end

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the rotary knob input handler.
// ----------------------------------------------------------------------------
// Drives ticks, knob edges and button edges into the block, mostly as tick
// runs sized around the current lockouts followed by an edge, with random
// noise mixed in. The configuration is changed between phases while the block
// is idle. Both sides stall at random; the result side also holds off for a
// long stretch once, and a long tick run checks edges against the widest
// lockouts. The checker beside the block predicts and compares.
module tb_top;
    import rkih_pkg::*;

    localparam int LED_COUNT  = 8;
    localparam int MODE_COUNT = 9;
    localparam int HOLD_CYCLES = 300;

    logic i_clk;
    logic i_rst_n;

    rkih_in_if  u_in_ch ();
    rkih_cfg_if u_cfg_ch ();
    rkih_out_if u_out_ch ();

    int err_cnt;
    int pending_cnt;

    int send_idle_pct;
    int recv_idle_pct;
    int rot_lock_cur;
    int btn_lock_cur;
    bit hold_start;
    logic recv_hold;

    rotary_knob_input_handler #(
        .LED_COUNT  (LED_COUNT),
        .MODE_COUNT (MODE_COUNT)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_ch),
        .i_cfg   (u_cfg_ch),
        .o_out   (u_out_ch)
    );

    rkih_checker #(
        .LED_COUNT  (LED_COUNT),
        .MODE_COUNT (MODE_COUNT)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (u_in_ch),
        .i_cfg_ch    (u_cfg_ch),
        .i_out_ch    (u_out_ch),
        .o_err_count (err_cnt),
        .o_pending   (pending_cnt)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // result side
    initial begin
        u_out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (recv_hold)
                u_out_ch.ready <= 1'b0;
            else
                u_out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one long hold-off on the result side, counted here
    initial begin
        recv_hold <= 1'b0;
        wait (hold_start);
        @(posedge i_clk);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        recv_hold <= 1'b0;
    end

    function automatic t_item knob_ev(input t_req_type req, input bit a, input bit b,
                                      input bit btn);
        return '{req_type: req, level_a: a, level_b: b, level_button: btn};
    endfunction

    task automatic send_item(input t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            u_in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        u_in_ch.valid        <= 1'b1;
        u_in_ch.req_type     <= it.req_type;
        u_in_ch.level_a      <= it.level_a;
        u_in_ch.level_b      <= it.level_b;
        u_in_ch.level_button <= it.level_button;
        @(posedge i_clk);
        while (!u_in_ch.ready) @(posedge i_clk);
    endtask

    // stop offering and wait until every result is back
    task automatic drain;
        u_in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(input int rot, input int btn, input int mid, input int big);
        t_cfg_addr addrs[4];
        int        vals[4];
        addrs = '{REG_ROTARY_LOCKOUT, REG_BUTTON_LOCKOUT, REG_WRAP_MID, REG_WRAP_LARGE};
        vals  = '{rot, btn, mid, big};
        for (int i = 0; i < 4; i++) begin
            u_cfg_ch.valid <= 1'b1;
            u_cfg_ch.addr  <= addrs[i];
            u_cfg_ch.data  <= t_cfg_data'(vals[i]);
            @(posedge i_clk);
            while (!u_cfg_ch.ready) @(posedge i_clk);
        end
        u_cfg_ch.valid <= 1'b0;
        rot_lock_cur = rot;
        btn_lock_cur = btn;
    endtask

    function automatic bit rbit();
        return 1'($urandom_range(1));
    endfunction

    // mostly tick runs near the lockout followed by an edge, some noise
    task automatic random_events(input int n_items);
        int        sent;
        int        kind;
        int        gap;
        t_req_type req;
        t_item     it;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 75) begin
                kind = $urandom_range(2);
                gap = ((kind == 2) ? btn_lock_cur : rot_lock_cur) + $urandom_range(2);
                if ($urandom_range(3) == 0) gap = gap - 2;
                if (gap < 0) gap = 0;
                repeat (gap) send_item(knob_ev(REQ_TICK, rbit(), rbit(), rbit()));
                sent = sent + gap;
                req = (kind == 0) ? REQ_A_FALL : ((kind == 1) ? REQ_B_FALL : REQ_BUTTON);
                it = knob_ev(req, rbit(), rbit(), rbit());
                if ($urandom_range(99) < 85) begin
                    case (req)
                        REQ_A_FALL: begin it.level_a = 1'b0; it.level_b = 1'b1; end
                        REQ_B_FALL: begin it.level_a = 1'b1; it.level_b = 1'b0; end
                        default:    it.level_button = 1'b1;
                    endcase
                end
                send_item(it);
            end else begin
                send_item(knob_ev(t_req_type'($urandom_range(3)), rbit(), rbit(), rbit()));
            end
            sent = sent + 1;
        end
    endtask

    initial begin
        t_item dir_q[$];
        int    mid;
        int    big;

        i_rst_n              <= 1'b0;
        u_in_ch.valid        <= 1'b0;
        u_in_ch.req_type     <= REQ_TICK;
        u_in_ch.level_a      <= 1'b0;
        u_in_ch.level_b      <= 1'b0;
        u_in_ch.level_button <= 1'b0;
        u_cfg_ch.valid       <= 1'b0;
        u_cfg_ch.addr        <= REG_ROTARY_LOCKOUT;
        u_cfg_ch.data        <= '0;
        hold_start    = 1'b0;
        send_idle_pct = 13;
        recv_idle_pct = 51;
        rot_lock_cur  = int'(ROTARY_LOCKOUT_RST);
        btn_lock_cur  = int'(BUTTON_LOCKOUT_RST);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // right after reset the elapsed count is zero, so this edge is locked out
        send_item(knob_ev(REQ_A_FALL, 1'b0, 1'b1, 1'b0));
        drain();
        configure(0, 0, int'(WRAP_MID_RST), int'(WRAP_LARGE_RST));

        dir_q = '{
            knob_ev(REQ_A_FALL, 1'b0, 1'b1, 1'b1),   // elapsed equals lockout
            knob_ev(REQ_TICK,   1'b1, 1'b1, 1'b1),
            knob_ev(REQ_A_FALL, 1'b1, 1'b1, 1'b0),   // wrong levels, lockout untouched
            knob_ev(REQ_A_FALL, 1'b0, 1'b1, 1'b0),
            knob_ev(REQ_TICK,   1'b0, 1'b0, 1'b0),
            knob_ev(REQ_B_FALL, 1'b1, 1'b0, 1'b0),
            knob_ev(REQ_TICK,   1'b0, 1'b1, 1'b0),
            knob_ev(REQ_B_FALL, 1'b1, 1'b0, 1'b1),   // down from zero
            knob_ev(REQ_TICK,   1'b1, 1'b0, 1'b1),
            knob_ev(REQ_A_FALL, 1'b0, 1'b1, 1'b1),   // up past the limit
            knob_ev(REQ_TICK,   1'b0, 1'b0, 1'b1),
            knob_ev(REQ_B_FALL, 1'b0, 1'b0, 1'b0),
            knob_ev(REQ_B_FALL, 1'b1, 1'b0, 1'b0),
            knob_ev(REQ_BUTTON, 1'b1, 1'b1, 1'b0),   // button low, ignored
            knob_ev(REQ_BUTTON, 1'b0, 1'b0, 1'b1),
            knob_ev(REQ_TICK,   1'b1, 1'b1, 1'b0),
            knob_ev(REQ_BUTTON, 1'b1, 1'b0, 1'b1),
            knob_ev(REQ_TICK,   1'b0, 1'b1, 1'b1),
            knob_ev(REQ_BUTTON, 1'b0, 1'b1, 1'b1),   // into mode 0, modulo
            knob_ev(REQ_TICK,   1'b0, 1'b0, 1'b0),
            knob_ev(REQ_A_FALL, 1'b0, 1'b1, 1'b0),
            knob_ev(REQ_TICK,   1'b1, 1'b1, 1'b1),
            knob_ev(REQ_A_FALL, 1'b0, 1'b1, 1'b1),
            knob_ev(REQ_TICK,   1'b1, 1'b0, 1'b0),
            knob_ev(REQ_BUTTON, 1'b1, 1'b1, 1'b1)
        };
        foreach (dir_q[i]) send_item(dir_q[i]);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 3) begin
                send_idle_pct = 51;
                recv_idle_pct = 13;
            end else if (ph == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            mid = ($urandom_range(1) == 1) ? $urandom_range(12) : $urandom_range(255);
            big = ($urandom_range(1) == 1) ? $urandom_range(12) : $urandom_range(255);
            case (ph)
                0:       configure(0, 0, 0, 1);
                1:       configure(3, 5, 255, 255);
                7:       configure($urandom_range(5), $urandom_range(6), 1, 0);
                default: configure($urandom_range(5), $urandom_range(6), mid, big);
            endcase
            random_events(55);
            drain();
        end

        // result side stalls for a long stretch while items keep coming
        configure(1, 2, 5, 30);
        hold_start = 1'b1;
        random_events(60);
        drain();

        // long tick run: the first knob edge and the first button edge pass just above the widest lockouts
        configure(1023, 1023, 20, 200);
        repeat (1025) send_item(knob_ev(REQ_TICK, rbit(), rbit(), rbit()));
        send_item(knob_ev(REQ_A_FALL, 1'b0, 1'b1, 1'b0));
        send_item(knob_ev(REQ_B_FALL, 1'b1, 1'b0, 1'b0));
        send_item(knob_ev(REQ_BUTTON, 1'b0, 1'b0, 1'b1));
        send_item(knob_ev(REQ_BUTTON, 1'b1, 1'b1, 1'b1));
        drain();
        repeat (8) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: files.f
design/rkih_pkg.sv
design/rkih_in_if.sv
design/rkih_out_if.sv
design/rkih_cfg_if.sv
design/rkih_step.sv
design/rotary_knob_input_handler.sv
tb/rkih_checker.sv
tb/tb_top.sv
